### hw/rtl/rpp_pkg.sv
// ----------------------------------------------------------------------------
// rpp_pkg
// shared widths and types for the radial point projection pipeline
// ----------------------------------------------------------------------------
package rpp_pkg;

	localparam int COORD_W = 32;               // q16.16 coordinate
	localparam int MAG_W   = COORD_W + 1;      // magnitude of a 33-bit difference
	localparam int SQ_W    = 2 * MAG_W - 1;    // square of a magnitude (<= 2^64)
	localparam int RAD_W   = SQ_W + 1;         // sum of three squares (< 2^66)
	localparam int LEN_W   = RAD_W / 2;        // integer square root width
	localparam int SREM_W  = LEN_W + 3;        // square root partial remainder
	localparam int RADIUS_W = 31;              // radius register width
	localparam int Q_W     = RADIUS_W;         // quotient never exceeds radius
	localparam int NUM_W   = MAG_W + RADIUS_W; // magnitude times radius
	localparam int DIVD_W  = NUM_W + 1;        // numerator plus rounding term
	localparam int NLANE   = 3;

	localparam int SQRT_CELLS = LEN_W;
	localparam int DIV_CELLS  = Q_W;

	// register indexes of the configuration port
	localparam logic [2:0] REG_CENTER_X = 3'd0;
	localparam logic [2:0] REG_CENTER_Y = 3'd1;
	localparam logic [2:0] REG_CENTER_Z = 3'd2;
	localparam logic [2:0] REG_RADIUS   = 3'd3;

	// reset radius is 1.0 in q16.16
	localparam logic [RADIUS_W-1:0] RADIUS_ONE = RADIUS_W'(32'h0001_0000);

	// side data that travels alongside each point
	typedef struct packed {
		logic                        zero;
		logic [NLANE-1:0]            neg;
		logic [NLANE-1:0][MAG_W-1:0] mag;
	} rpp_side_t;

endpackage

### hw/rtl/rpp_sqrt_cell.sv
// ----------------------------------------------------------------------------
// rpp_sqrt_cell
// one root bit of a digit-by-digit integer square root, registered
// ----------------------------------------------------------------------------
module rpp_sqrt_cell import rpp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              vld_in,
	input  rpp_side_t         side_in,
	input  logic [RAD_W-1:0]  rad_in,
	input  logic [SREM_W-1:0] rem_in,
	input  logic [LEN_W-1:0]  root_in,
	output logic              vld_q,
	output rpp_side_t         side_q,
	output logic [RAD_W-1:0]  rad_q,
	output logic [SREM_W-1:0] rem_q,
	output logic [LEN_W-1:0]  root_q
);

	logic [SREM_W-1:0] rem_sh;
	logic [SREM_W-1:0] trial;
	logic              ge;

	always_comb begin
		rem_sh = {rem_in[SREM_W-3:0], rad_in[RAD_W-1 -: 2]};
		trial  = {{(SREM_W-LEN_W-2){1'b0}}, root_in, 2'b01};
		ge     = (rem_sh >= trial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		side_q <= side_in;
		rad_q  <= {rad_in[RAD_W-3:0], 2'b00};
		rem_q  <= ge ? (rem_sh - trial) : rem_sh;
		root_q <= {root_in[LEN_W-2:0], ge};
	end

endmodule

### hw/rtl/rpp_div_cell.sv
// ----------------------------------------------------------------------------
// rpp_div_cell
// one quotient bit of a restoring divide, three lanes sharing a divisor
// ----------------------------------------------------------------------------
module rpp_div_cell import rpp_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        vld_in,
	input  rpp_side_t                   side_in,
	input  logic [LEN_W-1:0]            len_in,
	input  logic [NLANE-1:0][LEN_W-1:0] rem_in,
	input  logic [NLANE-1:0][Q_W-1:0]   low_in,
	input  logic [NLANE-1:0][Q_W-1:0]   quot_in,
	output logic                        vld_q,
	output rpp_side_t                   side_q,
	output logic [LEN_W-1:0]            len_q,
	output logic [NLANE-1:0][LEN_W-1:0] rem_q,
	output logic [NLANE-1:0][Q_W-1:0]   low_q,
	output logic [NLANE-1:0][Q_W-1:0]   quot_q
);

	logic [NLANE-1:0][LEN_W:0]   sh;
	logic [NLANE-1:0][LEN_W:0]   diff;
	logic [NLANE-1:0]            ge;

	always_comb begin
		for (int i = 0; i < NLANE; i++) begin
			sh[i]   = {rem_in[i], low_in[i][Q_W-1]};
			ge[i]   = (sh[i] >= {1'b0, len_in});
			diff[i] = sh[i] - {1'b0, len_in};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		side_q <= side_in;
		len_q  <= len_in;
		for (int i = 0; i < NLANE; i++) begin
			rem_q[i]  <= ge[i] ? diff[i][LEN_W-1:0] : sh[i][LEN_W-1:0];
			low_q[i]  <= {low_in[i][Q_W-2:0], 1'b0};
			quot_q[i] <= {quot_in[i][Q_W-2:0], ge[i]};
		end
	end

endmodule

### hw/rtl/radial_point_projection.sv
// ----------------------------------------------------------------------------
// radial_point_projection
// projects a q16.16 point onto a sphere of configured radius and center
// ----------------------------------------------------------------------------
// usage
// - a point transfers at a clock edge with start high and busy low; busy is
//   always low, so a new point may transfer in every cycle
// - for each transferred point, done is high for exactly one cycle with
//   out_x, out_y, out_z and zero_length valid
// - results leave in input order, one per point; the receiver cannot stall,
//   so nothing is ever held back or dropped
// - the chain holds 3 front stages (difference, squares, sum), 33 square
//   root cells (one root bit each), 2 scale stages (multiply by radius,
//   add rounding term), 31 divide cells (one quotient bit each, three
//   lanes), and the output register
// - configuration: cfg_we, cfg_index, cfg_data write center_x/y/z and
//   radius; write only while no point is in flight
// - reset clears all valid bits in the chain, center to 0, radius to 1.0
// - a point equal to the center gives zeros with zero_length set
// ----------------------------------------------------------------------------
module radial_point_projection import rpp_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic signed [COORD_W-1:0]  point_x,
	input  logic signed [COORD_W-1:0]  point_y,
	input  logic signed [COORD_W-1:0]  point_z,
	input  logic                       cfg_we,
	input  logic [2:0]                 cfg_index,
	input  logic [COORD_W-1:0]         cfg_data,
	output logic                       done,
	output logic signed [COORD_W-1:0]  out_x,
	output logic signed [COORD_W-1:0]  out_y,
	output logic signed [COORD_W-1:0]  out_z,
	output logic                       zero_length
);

	// configuration registers
	logic [NLANE-1:0][COORD_W-1:0] center_q;
	logic [RADIUS_W-1:0]           radius_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_q <= '0;
			radius_q <= RADIUS_ONE;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CENTER_X: center_q[0] <= cfg_data;
				REG_CENTER_Y: center_q[1] <= cfg_data;
				REG_CENTER_Z: center_q[2] <= cfg_data;
				REG_RADIUS:   radius_q    <= cfg_data[RADIUS_W-1:0];
				default:      ;
			endcase
		end
	end

	// the pipeline never refuses a point
	assign busy = 1'b0;

	logic transfer;
	assign transfer = start && !busy;

	// stage 1: difference to center, split into sign and magnitude
	logic [NLANE-1:0][COORD_W-1:0] pt;
	logic [NLANE-1:0][MAG_W-1:0]   dif;
	logic                          vld_s1;
	logic [NLANE-1:0]              neg_s1;
	logic [NLANE-1:0][MAG_W-1:0]   mag_s1;

	assign pt[0] = point_x;
	assign pt[1] = point_y;
	assign pt[2] = point_z;

	always_comb begin
		for (int i = 0; i < NLANE; i++) begin
			dif[i] = {pt[i][COORD_W-1], pt[i]} - {center_q[i][COORD_W-1], center_q[i]};
		end
	end

	// stage 2: squares; stage 3: sum of squares
	logic                          vld_s2;
	logic [NLANE-1:0]              neg_s2;
	logic [NLANE-1:0][MAG_W-1:0]   mag_s2;
	logic [NLANE-1:0][SQ_W-1:0]    sq_s2;
	logic                          vld_s3;
	rpp_side_t                     side_s3;
	logic [RAD_W-1:0]              sum_s3;
	logic [RAD_W-1:0]              sum_nx;

	assign sum_nx = {1'b0, sq_s2[0]} + {1'b0, sq_s2[1]} + {1'b0, sq_s2[2]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= transfer;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < NLANE; i++) begin
			neg_s1[i] <= dif[i][MAG_W-1];
			mag_s1[i] <= dif[i][MAG_W-1] ? (~dif[i] + 1'b1) : dif[i];
			sq_s2[i]  <= SQ_W'(mag_s1[i] * mag_s1[i]);
		end
		neg_s2       <= neg_s1;
		mag_s2       <= mag_s1;
		sum_s3       <= sum_nx;
		side_s3.zero <= (sum_nx == '0);
		side_s3.neg  <= neg_s2;
		side_s3.mag  <= mag_s2;
	end

	// square root chain: one root bit per cell
	logic      sq_vld  [0:SQRT_CELLS];
	rpp_side_t sq_side [0:SQRT_CELLS];
	logic [RAD_W-1:0]  sq_rad  [0:SQRT_CELLS];
	logic [SREM_W-1:0] sq_rem  [0:SQRT_CELLS];
	logic [LEN_W-1:0]  sq_root [0:SQRT_CELLS];

	assign sq_vld[0]  = vld_s3;
	assign sq_side[0] = side_s3;
	assign sq_rad[0]  = sum_s3;
	assign sq_rem[0]  = '0;
	assign sq_root[0] = '0;

	for (genvar c = 0; c < SQRT_CELLS; c++) begin : g_sqrt
		rpp_sqrt_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.vld_in  (sq_vld[c]),
			.side_in (sq_side[c]),
			.rad_in  (sq_rad[c]),
			.rem_in  (sq_rem[c]),
			.root_in (sq_root[c]),
			.vld_q   (sq_vld[c+1]),
			.side_q  (sq_side[c+1]),
			.rad_q   (sq_rad[c+1]),
			.rem_q   (sq_rem[c+1]),
			.root_q  (sq_root[c+1])
		);
	end

	// stage 4: magnitude times radius; stage 5: add half the length for rounding
	logic                          vld_s4;
	rpp_side_t                     side_s4;
	logic [LEN_W-1:0]              len_s4;
	logic [NLANE-1:0][NUM_W-1:0]   num_s4;
	logic                          vld_s5;
	rpp_side_t                     side_s5;
	logic [LEN_W-1:0]              len_s5;
	logic [NLANE-1:0][DIVD_W-1:0]  divd;
	logic [NLANE-1:0][LEN_W-1:0]   rem_s5;
	logic [NLANE-1:0][Q_W-1:0]     low_s5;

	always_comb begin
		for (int i = 0; i < NLANE; i++) begin
			divd[i] = {1'b0, num_s4[i]} + DIVD_W'(len_s4 >> 1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s4 <= sq_vld[SQRT_CELLS];
			vld_s5 <= vld_s4;
		end
	end

	// the dividend above the quotient bits is below the length, so it fits LEN_W
	always_ff @(posedge clk) begin
		side_s4 <= sq_side[SQRT_CELLS];
		len_s4  <= sq_root[SQRT_CELLS];
		for (int i = 0; i < NLANE; i++) begin
			num_s4[i] <= NUM_W'(sq_side[SQRT_CELLS].mag[i] * radius_q);
			rem_s5[i] <= divd[i][Q_W +: LEN_W];
			low_s5[i] <= divd[i][Q_W-1:0];
		end
		side_s5 <= side_s4;
		len_s5  <= len_s4;
	end

	// divide chain: one quotient bit per cell, all three components together
	logic      dv_vld  [0:DIV_CELLS];
	rpp_side_t dv_side [0:DIV_CELLS];
	logic [LEN_W-1:0]              dv_len  [0:DIV_CELLS];
	logic [NLANE-1:0][LEN_W-1:0]   dv_rem  [0:DIV_CELLS];
	logic [NLANE-1:0][Q_W-1:0]     dv_low  [0:DIV_CELLS];
	logic [NLANE-1:0][Q_W-1:0]     dv_quot [0:DIV_CELLS];

	assign dv_vld[0]  = vld_s5;
	assign dv_side[0] = side_s5;
	assign dv_len[0]  = len_s5;
	assign dv_rem[0]  = rem_s5;
	assign dv_low[0]  = low_s5;
	assign dv_quot[0] = '0;

	for (genvar c = 0; c < DIV_CELLS; c++) begin : g_div
		rpp_div_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.vld_in  (dv_vld[c]),
			.side_in (dv_side[c]),
			.len_in  (dv_len[c]),
			.rem_in  (dv_rem[c]),
			.low_in  (dv_low[c]),
			.quot_in (dv_quot[c]),
			.vld_q   (dv_vld[c+1]),
			.side_q  (dv_side[c+1]),
			.len_q   (dv_len[c+1]),
			.rem_q   (dv_rem[c+1]),
			.low_q   (dv_low[c+1]),
			.quot_q  (dv_quot[c+1])
		);
	end

	// output register: restore the sign, zero when the point hits the center
	// the quotient never exceeds radius, so no saturation is needed
	logic                          done_q;
	logic [NLANE-1:0][COORD_W-1:0] res_q;
	logic                          zero_q;
	rpp_side_t                     fin_side;
	logic [NLANE-1:0][COORD_W-1:0] res_nx;

	assign fin_side = dv_side[DIV_CELLS];

	always_comb begin
		for (int i = 0; i < NLANE; i++) begin
			if (fin_side.zero) begin
				res_nx[i] = '0;
			end else if (fin_side.neg[i]) begin
				res_nx[i] = ~{1'b0, dv_quot[DIV_CELLS][i]} + 1'b1;
			end else begin
				res_nx[i] = {1'b0, dv_quot[DIV_CELLS][i]};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= dv_vld[DIV_CELLS];
		end
	end

	always_ff @(posedge clk) begin
		res_q  <= res_nx;
		zero_q <= fin_side.zero;
	end

	assign done        = done_q;
	assign out_x       = res_q[0];
	assign out_y       = res_q[1];
	assign out_z       = res_q[2];
	assign zero_length = zero_q;

	// a point at the center always gives an all-zero vector
	a_zero_out : assert property (@(posedge clk) disable iff (!arst_n)
		(done && zero_length) |-> (out_x == '0 && out_y == '0 && out_z == '0))
		else $error("zero-length result carries nonzero components");

	// the x component magnitude stays within the radius while the radius holds steady
	a_within_radius : assert property (@(posedge clk) disable iff (!arst_n)
		(done && $stable(radius_q)) |->
		($signed({out_x[COORD_W-1], out_x}) <= $signed({2'b00, radius_q}) &&
		 $signed({out_x[COORD_W-1], out_x}) >= -$signed({2'b00, radius_q})))
		else $error("projected x exceeds radius");

	// the scale stage is never valid without a root from the square root chain
	a_chain_valid : assert property (@(posedge clk) disable iff (!arst_n)
		vld_s4 |-> $past(sq_vld[SQRT_CELLS]))
		else $error("scale stage valid without root");

endmodule

### tb/tb_radial_point_projection.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_radial_point_projection
// drives points through the projection pipeline under several center and
// radius settings, predicts every result in software and checks each one
// ----------------------------------------------------------------------------
module tb_radial_point_projection;
	import rpp_pkg::*;

	localparam int PIPE_LAT = 70;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic signed [COORD_W-1:0] point_x = '0, point_y = '0, point_z = '0;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [COORD_W-1:0] cfg_data = '0;
	logic done;
	logic signed [COORD_W-1:0] out_x, out_y, out_z;
	logic zero_length;

	// one projected point
	typedef struct {
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
		logic        zl;
	} proj_t;

	// one row of the directed table; known marks rows with a typed-in answer
	typedef struct {
		logic [31:0] px, py, pz;
		bit          known;
		proj_t       want;
	} dir_row_t;

	proj_t projection_queue[$];
	int err_count = 0;

	// predictor copy of the registers
	logic signed [31:0] ctr_x = 0, ctr_y = 0, ctr_z = 0;
	logic [30:0] rad = RADIUS_ONE;

	radial_point_projection u_top (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// scale one difference by radius / length, round half away, saturate
	function automatic logic [31:0] scale_lane(logic signed [33:0] d, logic [33:0] len);
		logic [33:0] mag;
		logic [67:0] num, q;
		mag = d < 0 ? -d : d;
		num = mag * rad;
		q = (num + (len >> 1)) / len;
		if (d < 0) begin
			if (q > 68'h80000000) q = 68'h80000000;
			return -q[31:0];
		end
		if (q > 68'h7FFFFFFF) q = 68'h7FFFFFFF;
		return q[31:0];
	endfunction

	function automatic proj_t project_point(logic signed [31:0] px, logic signed [31:0] py,
			logic signed [31:0] pz);
		logic signed [33:0] dx, dy, dz;
		logic [33:0] mx, my, mz, len, cand;
		logic [67:0] sumsq;
		proj_t r;
		dx = 34'(px) - 34'(ctr_x);
		dy = 34'(py) - 34'(ctr_y);
		dz = 34'(pz) - 34'(ctr_z);
		mx = dx < 0 ? -dx : dx;
		my = dy < 0 ? -dy : dy;
		mz = dz < 0 ? -dz : dz;
		sumsq = 68'(mx) * mx + 68'(my) * my + 68'(mz) * mz;
		if (sumsq == 0) begin
			r.x = 0; r.y = 0; r.z = 0; r.zl = 1'b1;
			return r;
		end
		len = 0;
		for (int b = 33; b >= 0; b--) begin
			cand = len | (34'd1 << b);
			if (68'(cand) * cand <= sumsq) len = cand;
		end
		r.x = scale_lane(dx, len);
		r.y = scale_lane(dy, len);
		r.z = scale_lane(dz, len);
		r.zl = 1'b0;
		return r;
	endfunction

	// register write, mirrored into the predictor with masking
	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_CENTER_X: ctr_x = val;
			REG_CENTER_Y: ctr_y = val;
			REG_CENTER_Z: ctr_z = val;
			REG_RADIUS:   rad = val[30:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// one point transfer; gaps only when idling is on
	task automatic send_point(logic [31:0] px, logic [31:0] py, logic [31:0] pz, bit idle_on);
		while (idle_on && $urandom_range(99) < 11) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		point_x <= px;
		point_y <= py;
		point_z <= pz;
		@(posedge clk);
		while (busy) @(posedge clk);
		projection_queue.push_back(project_point(px, py, pz));
	endtask

	// let the pipe empty before touching registers
	task automatic drain;
		start <= 1'b0;
		while (projection_queue.size() != 0) @(posedge clk);
		repeat (PIPE_LAT + 5) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_coord(int mode);
		case (mode)
			0: return $urandom();
			1: return $urandom_range(32'h0004_0000) - 32'h0002_0000;
			default: return (($urandom_range(1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000)
				^ $urandom_range(255);
		endcase
	endfunction

	// result check against the oldest prediction
	always @(posedge clk) begin
		proj_t e;
		if (arst_n && done) begin
			if (projection_queue.size() == 0) begin
				$error("result with no transfer pending");
				err_count++;
			end else begin
				e = projection_queue.pop_front();
				if (out_x !== e.x) begin
					$error("out_x exp %h got %h", e.x, out_x); err_count++;
				end
				if (out_y !== e.y) begin
					$error("out_y exp %h got %h", e.y, out_y); err_count++;
				end
				if (out_z !== e.z) begin
					$error("out_z exp %h got %h", e.z, out_z); err_count++;
				end
				if (zero_length !== e.zl) begin
					$error("zero_length exp %b got %b", e.zl, zero_length); err_count++;
				end
			end
		end
	end

	// directed table: typed answers only where obvious
	dir_row_t dir_tab[] = '{
		'{32'h0, 32'h0, 32'h0, 1, '{32'h0, 32'h0, 32'h0, 1'b1}},          // point at center
		'{32'h0001_0000, 32'h0, 32'h0, 1, '{32'h0001_0000, 32'h0, 32'h0, 1'b0}},
		'{32'h0, 32'hFFFF_0000, 32'h0, 1, '{32'h0, 32'hFFFF_0000, 32'h0, 1'b0}},
		'{32'h0, 32'h0, 32'h7FFF_FFFF, 1, '{32'h0, 32'h0, 32'h0001_0000, 1'b0}},
		'{32'h8000_0000, 32'h0, 32'h0, 1, '{32'hFFFF_0000, 32'h0, 32'h0, 1'b0}},
		'{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, '{0, 0, 0, 0}},
		'{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, '{0, 0, 0, 0}},
		'{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 0, '{0, 0, 0, 0}},
		'{32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0001, 0, '{0, 0, 0, 0}},
		'{32'h0003_0000, 32'h0004_0000, 32'h0, 0, '{0, 0, 0, 0}},
		'{32'h1234_5678, 32'hEDCB_A987, 32'h5555_AAAA, 0, '{0, 0, 0, 0}}
	};

	initial begin
		proj_t e;
		int mode;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows under reset registers
		foreach (dir_tab[i]) begin
			if (dir_tab[i].known) begin
				e = project_point(dir_tab[i].px, dir_tab[i].py, dir_tab[i].pz);
				if (e.x !== dir_tab[i].want.x || e.y !== dir_tab[i].want.y ||
						e.z !== dir_tab[i].want.z || e.zl !== dir_tab[i].want.zl) begin
					$error("table row %0d disagrees with predictor", i); err_count++;
				end
			end
			send_point(dir_tab[i].px, dir_tab[i].py, dir_tab[i].pz, 0);
		end
		drain();

		// extreme registers: far center, full radius, plus a masked radius bit and a dead index
		write_reg(REG_CENTER_X, 32'h8000_0000);
		write_reg(REG_CENTER_Y, 32'h7FFF_FFFF);
		write_reg(REG_CENTER_Z, 32'hFFFF_FFFF);
		write_reg(REG_RADIUS, 32'hFFFF_FFFF);
		write_reg(3'd5, 32'h1234_5678);
		send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0);       // at center
		send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 0);
		send_point(32'h8000_0001, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0);
		drain();
		write_reg(REG_RADIUS, 32'h0);                                    // zero radius
		send_point(32'h0, 32'h0, 32'h0, 0);
		send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0);
		drain();

		// random phases, fresh registers each time
		for (int ph = 0; ph < 8; ph++) begin
			write_reg(REG_CENTER_X, (ph % 3 == 0) ? 32'h0 : rand_coord(ph % 3));
			write_reg(REG_CENTER_Y, (ph % 3 == 0) ? 32'h0 : rand_coord(ph % 3));
			write_reg(REG_CENTER_Z, (ph % 3 == 0) ? 32'h0 : rand_coord(ph % 3));
			case (ph % 4)
				0: write_reg(REG_RADIUS, 32'h7FFF_FFFF);
				1: write_reg(REG_RADIUS, 32'h0);
				2: write_reg(REG_RADIUS, $urandom_range(32'h0010_0000));
				default: write_reg(REG_RADIUS, $urandom());
			endcase
			for (int n = 0; n < 140; n++) begin
				mode = $urandom_range(2);
				if ($urandom_range(19) == 0)
					send_point(ctr_x, ctr_y, ctr_z, ph != 2);                // hit the center
				else
					send_point(32'(ctr_x) + rand_coord(mode), 32'(ctr_y) + rand_coord(mode),
						32'(ctr_z) + rand_coord(mode), ph != 2);
			end
			drain();
		end

		if (err_count == 0)
			$display("tb_radial_point_projection: PASS");
		else
			$display("tb_radial_point_projection: FAIL");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("tb_radial_point_projection: FAIL");
		$finish;
	end

endmodule
